### rtl/dbd_pkg.sv
package dbd_pkg;

    localparam int DEF_MAX_CLASSES    = 128;
    localparam int DEF_EXP_TABLE_BITS = 10;

    localparam int LABEL_W = 7;
    localparam int SCORE_W = 16;
    localparam int OFF_W   = 16;
    localparam int ANC_W   = 16;
    localparam int DIM_W   = 13;
    localparam int VAR_W   = 16;
    localparam int PIX_W   = 16;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 16;

    localparam int ROM_W   = 32;
    localparam int RND_W   = 40;
    localparam int HALF_W  = 45;
    localparam int EDGE_W  = 47;
    localparam int PMUL_W  = 61;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    localparam logic [CFG_AW-1:0] CFG_SCORE_THRESHOLD = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_IMAGE_WIDTH     = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_IMAGE_HEIGHT    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_CENTER_VARIANCE = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_SIZE_VARIANCE   = 3'd4;

    localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
    localparam logic [63:0]        LN2_Q30   = 64'd744261118;
    localparam int                 SERIES_TERMS = 12;

    typedef struct packed {
        logic [SCORE_W-1:0] score_threshold;
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
        logic [VAR_W-1:0]   center_variance;
        logic [VAR_W-1:0]   size_variance;
    } t_cfg;

    typedef struct packed {
        logic [LABEL_W-1:0]      label;
        logic [SCORE_W-1:0]      score;
        logic signed [OFF_W-1:0] offset_cx;
        logic signed [OFF_W-1:0] offset_cy;
        logic signed [OFF_W-1:0] offset_w;
        logic signed [OFF_W-1:0] offset_h;
        logic [ANC_W-1:0]        anchor_cx;
        logic [ANC_W-1:0]        anchor_cy;
        logic [ANC_W-1:0]        anchor_w;
        logic [ANC_W-1:0]        anchor_h;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_ROUND,
        ST_SCALE,
        ST_HALF,
        ST_EDGE,
        ST_PIX,
        ST_DONE
    } t_state;

    // 2^(idx/2^bits) in Q2.30 by a truncated series
    function automatic logic [ROM_W-1:0] exp2_entry(input int idx, input int bits);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        y = (64'(idx) * LN2_Q30 + (64'd1 << (bits - 1))) >> bits;
        term = 64'd1 << 30;
        sum = term;
        for (int k = 1; k <= SERIES_TERMS; k++) begin
            term = ((term * y) >> 30) / 64'(k);
            sum = sum + term;
        end
        return sum[ROM_W-1:0];
    endfunction

    // clip to [0, dim-1] pixels, convert to Q12.4 and saturate
    function automatic logic [PIX_W-1:0] to_pixels(input logic signed [PMUL_W-1:0] p,
                                                   input logic [DIM_W-1:0] dim);
        logic signed [DIM_W+1:0]   dm1;
        logic signed [PMUL_W-1:0]  lim;
        logic signed [PMUL_W-1:0]  c;
        logic [PMUL_W-1:0]         q;
        dm1 = $signed({2'b00, dim}) - 15'sd1;
        lim = {{(PMUL_W-DIM_W-2-32){dm1[DIM_W+1]}}, dm1, 32'b0};
        c = p;
        if (c > lim) begin
            c = lim;
        end
        if (c < 0) begin
            c = '0;
        end
        q = (PMUL_W'(c) + (PMUL_W'(1) << 27)) >> 28;
        return (q > PMUL_W'(16'hFFFF)) ? 16'hFFFF : q[PIX_W-1:0];
    endfunction

endpackage

### rtl/dbd_front.sv
module dbd_front
    import dbd_pkg::*;
#(
    parameter int MAX_CLASSES = DEF_MAX_CLASSES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [SCORE_W-1:0]      i_class_score,
    input  logic                    i_last_class,
    input  logic signed [OFF_W-1:0] i_offset_cx,
    input  logic signed [OFF_W-1:0] i_offset_cy,
    input  logic signed [OFF_W-1:0] i_offset_w,
    input  logic signed [OFF_W-1:0] i_offset_h,
    input  logic [ANC_W-1:0]        i_anchor_cx,
    input  logic [ANC_W-1:0]        i_anchor_cy,
    input  logic [ANC_W-1:0]        i_anchor_w,
    input  logic [ANC_W-1:0]        i_anchor_h,
    input  logic [SCORE_W-1:0]      i_score_threshold,
    input  logic                    i_q_full,
    output logic                    o_push,
    output t_job                    o_job
);

    localparam logic [LABEL_W-1:0] CNT_LIMIT =
        (MAX_CLASSES - 1 > 127) ? 7'd127 : LABEL_W'(MAX_CLASSES - 1);

    logic [LABEL_W-1:0] r_count, n_count;
    logic [SCORE_W-1:0] r_best, n_best;
    logic [LABEL_W-1:0] r_label, n_label;
    logic               accept;
    logic               upd;
    logic [SCORE_W-1:0] cur_best;
    logic [LABEL_W-1:0] cur_label;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        upd       = (r_count != '0) && (i_class_score > r_best);
        cur_best  = upd ? i_class_score : r_best;
        cur_label = upd ? r_count : r_label;
        n_count   = r_count;
        n_best    = r_best;
        n_label   = r_label;
        if (accept) begin
            if (i_last_class) begin
                n_count = '0;
                n_best  = '0;
                n_label = '0;
            end else begin
                n_best  = cur_best;
                n_label = cur_label;
                if (r_count < CNT_LIMIT) begin
                    n_count = r_count + 7'd1;
                end
            end
        end
    end

    assign o_push = accept && i_last_class && (cur_label != '0)
                    && (cur_best > i_score_threshold);

    always_comb begin
        o_job.label     = cur_label;
        o_job.score     = cur_best;
        o_job.offset_cx = i_offset_cx;
        o_job.offset_cy = i_offset_cy;
        o_job.offset_w  = i_offset_w;
        o_job.offset_h  = i_offset_h;
        o_job.anchor_cx = i_anchor_cx;
        o_job.anchor_cy = i_anchor_cy;
        o_job.anchor_w  = i_anchor_w;
        o_job.anchor_h  = i_anchor_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_best  <= '0;
            r_label <= '0;
        end else begin
            r_count <= n_count;
            r_best  <= n_best;
            r_label <= n_label;
        end
    end

endmodule

### rtl/dbd_queue.sv
module dbd_queue
    import dbd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (QUEUE_AW+1)'(i_push) - (QUEUE_AW+1)'(i_pop);
        end
    end

endmodule

### rtl/dbd_back.sv
module dbd_back
    import dbd_pkg::*;
#(
    parameter int EXP_TABLE_BITS = DEF_EXP_TABLE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_valid,
    input  t_job               i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [LABEL_W-1:0] o_class_label,
    output logic [SCORE_W-1:0] o_best_score,
    output logic [PIX_W-1:0]   o_left_x,
    output logic [PIX_W-1:0]   o_top_y,
    output logic [PIX_W-1:0]   o_right_x,
    output logic [PIX_W-1:0]   o_bottom_y
);

    localparam int ROM_DEPTH = 1 << EXP_TABLE_BITS;

    typedef logic [ROM_W-1:0] t_rom [ROM_DEPTH];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            rom[i] = exp2_entry(i, EXP_TABLE_BITS);
        end
        return rom;
    endfunction

    localparam t_rom EXP_ROM = build_rom();

    t_state r_state, n_state;
    logic   load_out;
    logic   r_valid;

    t_job                      r_job;
    logic signed [32:0]        r_cmx, r_cmy, r_smx, r_smy;
    logic signed [49:0]        r_pcx, r_pcy;
    logic signed [64:0]        r_tx, r_ty;
    logic signed [RND_W-1:0]   r_rcx, r_rcy, r_cx, r_cy;
    logic [ROM_W-1:0]          r_ex, r_ey;
    logic [4:0]                r_shx, r_shy;
    logic [47:0]               r_prx, r_pry;
    logic [HALF_W-1:0]         r_hwx, r_hwy;
    logic signed [EDGE_W-1:0]  r_lx, r_ty_e, r_rx, r_by;
    logic signed [PMUL_W-1:0]  r_plx, r_pty, r_prx_p, r_pby;

    logic [62:0]               ux, uy;
    logic [48:0]               hsx, hsy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_q_valid) begin
                n_state = ST_MUL1;
            end
            ST_MUL1:  n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_ROUND;
            ST_ROUND: n_state = ST_SCALE;
            ST_SCALE: n_state = ST_HALF;
            ST_HALF:  n_state = ST_EDGE;
            ST_EDGE:  n_state = ST_PIX;
            ST_PIX:   n_state = ST_DONE;
            ST_DONE:  if (!r_valid || i_ready) begin
                n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: o_pop    = i_q_valid;
            ST_DONE: load_out = !r_valid || i_ready;
            default: begin
                o_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;

    assign ux  = r_tx[62:0] + (63'd1 << 62);
    assign uy  = r_ty[62:0] + (63'd1 << 62);
    assign hsx = 49'(r_prx) + (49'd1 << (r_shx - 5'd1));
    assign hsy = 49'(r_pry) + (49'd1 << (r_shy - 5'd1));

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == ST_MUL1) begin
            r_cmx <= $signed({1'b0, i_cfg.center_variance}) * r_job.offset_cx;
            r_cmy <= $signed({1'b0, i_cfg.center_variance}) * r_job.offset_cy;
            r_smx <= $signed({1'b0, i_cfg.size_variance}) * r_job.offset_w;
            r_smy <= $signed({1'b0, i_cfg.size_variance}) * r_job.offset_h;
        end
        if (r_state == ST_MUL2) begin
            r_pcx <= r_cmx * $signed({1'b0, r_job.anchor_w});
            r_pcy <= r_cmy * $signed({1'b0, r_job.anchor_h});
            r_tx  <= r_smx * LOG2E_Q30;
            r_ty  <= r_smy * LOG2E_Q30;
        end
        if (r_state == ST_ROUND) begin
            r_rcx <= RND_W'((r_pcx + (r_pcx[49] ? 50'sd2047 : 50'sd2048)) >>> 12);
            r_rcy <= RND_W'((r_pcy + (r_pcy[49] ? 50'sd2047 : 50'sd2048)) >>> 12);
            r_shx <= 5'd31 - ux[62:58];
            r_shy <= 5'd31 - uy[62:58];
            r_ex  <= EXP_ROM[ux[57 -: EXP_TABLE_BITS]];
            r_ey  <= EXP_ROM[uy[57 -: EXP_TABLE_BITS]];
        end
        if (r_state == ST_SCALE) begin
            r_prx <= 48'(r_ex) * 48'(r_job.anchor_w);
            r_pry <= 48'(r_ey) * 48'(r_job.anchor_h);
            r_cx  <= $signed({8'b0, r_job.anchor_cx, 16'b0}) + r_rcx;
            r_cy  <= $signed({8'b0, r_job.anchor_cy, 16'b0}) + r_rcy;
        end
        if (r_state == ST_HALF) begin
            r_hwx <= HALF_W'(hsx >> r_shx);
            r_hwy <= HALF_W'(hsy >> r_shy);
        end
        if (r_state == ST_EDGE) begin
            r_lx   <= EDGE_W'(r_cx) - $signed({2'b0, r_hwx});
            r_rx   <= EDGE_W'(r_cx) + $signed({2'b0, r_hwx});
            r_ty_e <= EDGE_W'(r_cy) - $signed({2'b0, r_hwy});
            r_by   <= EDGE_W'(r_cy) + $signed({2'b0, r_hwy});
        end
        if (r_state == ST_PIX) begin
            r_plx   <= r_lx   * $signed({1'b0, i_cfg.image_width});
            r_prx_p <= r_rx   * $signed({1'b0, i_cfg.image_width});
            r_pty   <= r_ty_e * $signed({1'b0, i_cfg.image_height});
            r_pby   <= r_by   * $signed({1'b0, i_cfg.image_height});
        end
        if (load_out) begin
            o_class_label <= r_job.label;
            o_best_score  <= r_job.score;
            o_left_x      <= to_pixels(r_plx, i_cfg.image_width);
            o_right_x     <= to_pixels(r_prx_p, i_cfg.image_width);
            o_top_y       <= to_pixels(r_pty, i_cfg.image_height);
            o_bottom_y    <= to_pixels(r_pby, i_cfg.image_height);
        end
    end

endmodule

### rtl/detection_box_decode_core.sv
// Detection box decode: streams one class score per cycle per prior (class 0
// is background) and keeps a running argmax. On the item flagged last_class,
// the prior is kept when its best label is nonzero and its score exceeds the
// threshold; its offsets and anchors then go through a two-entry queue to a
// decode sequencer that emits label, score and the clipped Q12.4 corners.
// Score items are taken one per cycle while the queue has room; each kept
// prior occupies the decode sequencer (multiply, round, exp-table lookup,
// scale, half-width, edge, pixel conversion) until it is through, so the
// input stalls only when kept priors outpace it or a held output fills
// the queue. Configuration registers must be written only while the block
// is idle; the block itself does not enforce this.
module detection_box_decode_core
    import dbd_pkg::*;
#(
    parameter int MAX_CLASSES    = DEF_MAX_CLASSES,
    parameter int EXP_TABLE_BITS = DEF_EXP_TABLE_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_AW-1:0]       i_cfg_index,
    input  logic [CFG_DW-1:0]       i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [SCORE_W-1:0]      i_class_score,
    input  logic                    i_last_class,
    input  logic signed [OFF_W-1:0] i_offset_cx,
    input  logic signed [OFF_W-1:0] i_offset_cy,
    input  logic signed [OFF_W-1:0] i_offset_w,
    input  logic signed [OFF_W-1:0] i_offset_h,
    input  logic [ANC_W-1:0]        i_anchor_cx,
    input  logic [ANC_W-1:0]        i_anchor_cy,
    input  logic [ANC_W-1:0]        i_anchor_w,
    input  logic [ANC_W-1:0]        i_anchor_h,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [LABEL_W-1:0]      o_class_label,
    output logic [SCORE_W-1:0]      o_best_score,
    output logic [PIX_W-1:0]        o_left_x,
    output logic [PIX_W-1:0]        o_top_y,
    output logic [PIX_W-1:0]        o_right_x,
    output logic [PIX_W-1:0]        o_bottom_y
);

    t_cfg r_cfg;
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_job push_job;
    t_job head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.score_threshold <= 16'd3277;
            r_cfg.image_width     <= 13'd640;
            r_cfg.image_height    <= 13'd480;
            r_cfg.center_variance <= 16'd6554;
            r_cfg.size_variance   <= 16'd13107;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SCORE_THRESHOLD: r_cfg.score_threshold <= i_cfg_data;
                CFG_IMAGE_WIDTH:     r_cfg.image_width     <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:    r_cfg.image_height    <= i_cfg_data[DIM_W-1:0];
                CFG_CENTER_VARIANCE: r_cfg.center_variance <= i_cfg_data;
                CFG_SIZE_VARIANCE:   r_cfg.size_variance   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dbd_front #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .o_ready          (o_in_ready),
        .i_class_score    (i_class_score),
        .i_last_class     (i_last_class),
        .i_offset_cx      (i_offset_cx),
        .i_offset_cy      (i_offset_cy),
        .i_offset_w       (i_offset_w),
        .i_offset_h       (i_offset_h),
        .i_anchor_cx      (i_anchor_cx),
        .i_anchor_cy      (i_anchor_cy),
        .i_anchor_w       (i_anchor_w),
        .i_anchor_h       (i_anchor_h),
        .i_score_threshold(r_cfg.score_threshold),
        .i_q_full         (q_full),
        .o_push           (q_push),
        .o_job            (push_job)
    );

    dbd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_job  (push_job),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_job  (head_job)
    );

    dbd_back #(
        .EXP_TABLE_BITS(EXP_TABLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_job        (head_job),
        .o_pop        (q_pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_class_label(o_class_label),
        .o_best_score (o_best_score),
        .o_left_x     (o_left_x),
        .o_top_y      (o_top_y),
        .o_right_x    (o_right_x),
        .o_bottom_y   (o_bottom_y)
    );

endmodule
